// ----- src/power_thermal_mode_governor_assert.svh -----
// ----------------------------------------------------------------------------
// Power thermal mode governor assertion macros
// Shared property shapes for the governor's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef POWER_THERMAL_MODE_GOVERNOR_ASSERT_SVH
`define POWER_THERMAL_MODE_GOVERNOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTMG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTMG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ptmg_pkg.sv -----
// ----------------------------------------------------------------------------
// Power thermal mode governor package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ptmg_pkg;

  // Field widths.
  localparam int BATT_W     = 8;
  localparam int PCT_W      = 7;
  localparam int TEMP_W     = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Battery readings above a full charge are clipped to this.
  localparam logic [PCT_W-1:0] BATT_FULL_PCT = 7'd100;

  // Register reset values.
  localparam logic [PCT_W-1:0]         RST_ENTER_BATT = 7'd30;
  localparam logic signed [TEMP_W-1:0] RST_ENTER_TEMP = 16'sd650;
  localparam logic [PCT_W-1:0]         RST_LEAVE_BATT = 7'd40;
  localparam logic signed [TEMP_W-1:0] RST_LEAVE_TEMP = 16'sd550;
  localparam logic [TIME_W-1:0]        RST_HOLD_TIME  = 32'd120000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTER_BATT = 3'd0,
    REG_ENTER_TEMP = 3'd1,
    REG_LEAVE_BATT = 3'd2,
    REG_LEAVE_TEMP = 3'd3,
    REG_HOLD_TIME  = 3'd4
  } reg_index_t;

  // Operating mode.
  typedef enum logic {
    MODE_STANDARD   = 1'b0,
    MODE_EFFICIENCY = 1'b1
  } mode_t;

  // Current threshold settings.
  typedef struct packed {
    logic [PCT_W-1:0]         enter_eff_battery_pct;
    logic signed [TEMP_W-1:0] enter_eff_temp_dc;
    logic [PCT_W-1:0]         leave_eff_battery_pct;
    logic signed [TEMP_W-1:0] leave_eff_temp_dc;
    logic [TIME_W-1:0]        hold_time_ms;
  } cfg_t;

  // Classified sample handed from the input stage to the mode core.
  typedef struct packed {
    logic              low;
    logic              hot;
    logic              batt_rec;
    logic              temp_rec;
    logic [TIME_W-1:0] time_ms;
  } flags_t;

endpackage

`default_nettype wire

// ----- src/ptmg_if.sv -----
// ----------------------------------------------------------------------------
// Power thermal mode governor channels
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Telemetry sample channel.
interface ptmg_sample_if import ptmg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [BATT_W-1:0] battery_level;
  logic signed [TEMP_W-1:0] temperature_dc;
  logic                     temperature_ok;
  logic [TIME_W-1:0]        time_ms;

  modport source (output valid, output battery_level, output temperature_dc,
                  output temperature_ok, output time_ms, input ready);
  modport sink   (input valid, input battery_level, input temperature_dc,
                  input temperature_ok, input time_ms, output ready);
endinterface

// Mode result channel.
interface ptmg_result_if import ptmg_pkg::*; ();
  logic valid;
  logic ready;
  logic mode_out;
  logic switched;

  modport source (output valid, output mode_out, output switched, input ready);
  modport sink   (input valid, input mode_out, input switched, output ready);
endinterface

// Register write channel.
interface ptmg_cfg_if import ptmg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ptmg_cfg.sv -----
// ----------------------------------------------------------------------------
// Power thermal mode governor configuration registers
// Holds the thresholds and the hold time; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmg_cfg import ptmg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ptmg_cfg_if.sink   cfg,
  output cfg_t       regs
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enter_eff_battery_pct <= RST_ENTER_BATT;
      regs.enter_eff_temp_dc     <= RST_ENTER_TEMP;
      regs.leave_eff_battery_pct <= RST_LEAVE_BATT;
      regs.leave_eff_temp_dc     <= RST_LEAVE_TEMP;
      regs.hold_time_ms          <= RST_HOLD_TIME;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_ENTER_BATT: regs.enter_eff_battery_pct <= cfg.data[PCT_W-1:0];
        REG_ENTER_TEMP: regs.enter_eff_temp_dc     <= cfg.data[TEMP_W-1:0];
        REG_LEAVE_BATT: regs.leave_eff_battery_pct <= cfg.data[PCT_W-1:0];
        REG_LEAVE_TEMP: regs.leave_eff_temp_dc     <= cfg.data[TEMP_W-1:0];
        REG_HOLD_TIME:  regs.hold_time_ms          <= cfg.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/ptmg_classify.sv -----
// ----------------------------------------------------------------------------
// Power thermal mode governor input stage
// Registers each sample as threshold flags plus its timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmg_classify import ptmg_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  ptmg_sample_if.sink sample,
  input  cfg_t        regs,
  input  wire logic   advance,
  output logic        flags_valid,
  output flags_t      flags
);

  logic             batt_known;
  logic [PCT_W-1:0] batt_sat;
  logic             temp_ok;
  flags_t           flags_next;

  // The stage takes a beat when empty or when its content moves on.
  assign sample.ready = !flags_valid || advance;

  // Clip the battery reading and compare against the thresholds.
  always_comb begin
    batt_known = !sample.battery_level[BATT_W-1];
    batt_sat   = (sample.battery_level[PCT_W-1:0] > BATT_FULL_PCT) ?
                 BATT_FULL_PCT : sample.battery_level[PCT_W-1:0];
    temp_ok    = sample.temperature_ok;

    flags_next.low      = batt_known && (batt_sat < regs.enter_eff_battery_pct);
    flags_next.batt_rec = batt_known && (batt_sat > regs.leave_eff_battery_pct);
    flags_next.hot      = temp_ok && (sample.temperature_dc > regs.enter_eff_temp_dc);
    flags_next.temp_rec = temp_ok && (sample.temperature_dc < regs.leave_eff_temp_dc);
    flags_next.time_ms  = sample.time_ms;
  end

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags_valid <= 1'b0;
    end else if (sample.ready) begin
      flags_valid <= sample.valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      flags <= flags_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/ptmg_core.sv -----
// ----------------------------------------------------------------------------
// Power thermal mode governor mode core
// Applies the hysteresis and hold timer and registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "power_thermal_mode_governor_assert.svh"

module ptmg_core import ptmg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  cfg_t          regs,
  input  wire logic     flags_valid,
  input  flags_t        flags,
  output logic          advance,
  ptmg_result_if.source result
);

  mode_t             mode;
  mode_t             mode_next;
  logic              armed;
  logic              armed_next;
  logic [TIME_W-1:0] start_ms;
  logic [TIME_W-1:0] start_ms_next;
  logic [TIME_W-1:0] elapsed;
  logic              fire;
  logic              res_valid;
  logic              res_mode;
  logic              res_switched;

  // The result register frees up when empty or when its beat is taken.
  assign advance = !res_valid || result.ready;
  assign fire    = flags_valid && advance;

  assign result.valid    = res_valid;
  assign result.mode_out = res_mode;
  assign result.switched = res_switched;

  // Wrapping time since the recovery timer was armed.
  assign elapsed = flags.time_ms - start_ms;

  // Hysteresis decision.
  always_comb begin
    mode_next     = mode;
    armed_next    = armed;
    start_ms_next = start_ms;
    case (mode)
      MODE_STANDARD: begin
        armed_next = 1'b0;
        if (flags.low || flags.hot) begin
          mode_next = MODE_EFFICIENCY;
        end
      end
      MODE_EFFICIENCY: begin
        if (flags.batt_rec && flags.temp_rec) begin
          if (!armed) begin
            armed_next    = 1'b1;
            start_ms_next = flags.time_ms;
          end else if (elapsed >= regs.hold_time_ms) begin
            mode_next = MODE_STANDARD;
          end
        end else begin
          armed_next = 1'b0;
        end
      end
      default: begin
        mode_next = MODE_STANDARD;
      end
    endcase
  end

  // Governor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_STANDARD;
      armed    <= 1'b0;
      start_ms <= '0;
    end else if (fire) begin
      mode     <= mode_next;
      armed    <= armed_next;
      start_ms <= start_ms_next;
    end
  end

  // Result register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= flags_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      res_mode     <= mode_next;
      res_switched <= (mode_next != mode);
    end
  end

  // A sample seen in standard mode always leaves the timer disarmed.
  `PTMG_ASSERT_NEXT(a_std_disarms, fire && (mode == MODE_STANDARD), !armed,
                    "timer armed after a standard mode sample")
  // Without an armed timer an efficiency mode sample cannot switch.
  `PTMG_ASSERT_NEXT(a_no_switch_unarmed,
                    fire && (mode == MODE_EFFICIENCY) && !armed, !res_switched,
                    "switch to standard mode without an armed timer")
  // The result beat reports the mode that the state register now holds.
  `PTMG_ASSERT_NEXT(a_result_matches_state, fire,
                    res_valid && (res_mode == mode),
                    "result mode differs from governor state")

endmodule

`default_nettype wire

// ----- src/power_thermal_mode_governor.sv -----
// Path: a sample beat goes to the input register, then to the result register.
// Throughput: one sample per cycle while results are taken; input and result
// registers each take a new beat whenever the stage after them moves on.
// Reset (rst, synchronous): standard mode, timer disarmed, start time zero,
// thresholds at their defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
// Power thermal mode governor
// Dual-threshold hysteresis between standard and efficiency mode with a hold
// time before returning to standard mode.
// ----------------------------------------------------------------------------
`default_nettype none

module power_thermal_mode_governor import ptmg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  ptmg_sample_if.sink   sample,
  ptmg_cfg_if.sink      cfg,
  ptmg_result_if.source result
);

  cfg_t   regs;
  flags_t flags;
  logic   flags_valid;
  logic   advance;

  // Threshold registers.
  ptmg_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Input register with threshold comparisons.
  ptmg_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .regs        (regs),
    .advance     (advance),
    .flags_valid (flags_valid),
    .flags       (flags)
  );

  // Mode state and result register.
  ptmg_core u_core (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .flags_valid (flags_valid),
    .flags       (flags),
    .advance     (advance),
    .result      (result)
  );

endmodule

`default_nettype wire
